@@ rtl/tcpq_pkg.sv @@
// Shared constants and types for the two-class priority queue.
`default_nettype none

package tcpq_pkg;

   // Entries held per class.
   localparam int CLASS_DEPTH = 16;
   // Identifier bits kept in storage, never more than the 16-bit port carries.
   localparam int ID_BITS     = 16;
   localparam int PORT_BITS   = 16;
   localparam int STORE_BITS  = (ID_BITS < PORT_BITS) ? ID_BITS : PORT_BITS;
   // Occupancy counter must hold CLASS_DEPTH itself.
   localparam int COUNT_BITS  = $clog2(CLASS_DEPTH + 1);
   // Total occupancy field and its saturation value.
   localparam int TOTAL_BITS  = 6;
   localparam int TOTAL_MAX   = (1 << TOTAL_BITS) - 1;

   // Item codes on req_mode.
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_SERVE   = 1'b1;

   // Per-cell control from the class row.
   typedef struct packed {
      logic shift;   // take the neighbour's entry (head moves on)
      logic load;    // write the incoming identifier here
   } tcpq_cell_ctrl_type;

   // Class status towards the top level.
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  full;
      logic                  empty;
      logic [STORE_BITS-1:0] head;
   } tcpq_class_stat_type;

endpackage

`default_nettype wire

@@ rtl/tcpq_cell.sv @@
// One storage cell of a class row: holds one identifier, loads or shifts.
`default_nettype none

module tcpq_cell (
   input  wire                              clock,
   input  tcpq_pkg::tcpq_cell_ctrl_type     ctrl,
   input  wire  [tcpq_pkg::STORE_BITS-1:0]  load_data,
   input  wire  [tcpq_pkg::STORE_BITS-1:0]  next_data,
   output logic [tcpq_pkg::STORE_BITS-1:0]  data
);
   import tcpq_pkg::*;

   logic [STORE_BITS-1:0] data_ff;
   logic [STORE_BITS-1:0] data_in;

   // Shift towards the head on serve, load at the tail on enqueue
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.load) begin
         data_in = load_data;
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ rtl/tcpq_class.sv @@
// One class: a row of cells with the head in cell 0 and an occupancy count.
`default_nettype none

module tcpq_class (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  wire                              pop,
   input  wire  [tcpq_pkg::STORE_BITS-1:0]  push_data,
   output tcpq_pkg::tcpq_class_stat_type    stat
);
   import tcpq_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [STORE_BITS-1:0] cell_data [CLASS_DEPTH];

   // Row of cells; each hands its entry to the one nearer the head on pop
   for (genvar i = 0; i < CLASS_DEPTH; i++) begin : g_cell
      tcpq_cell_ctrl_type    ctrl;
      logic [STORE_BITS-1:0] next_data;

      assign ctrl.shift = pop;
      assign ctrl.load  = push && (count_ff == COUNT_BITS'(i));

      if (i == CLASS_DEPTH - 1) begin : g_last
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      tcpq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (push_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   // Occupancy; push and pop are never raised together
   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.count = count_ff;
   assign stat.full  = (count_ff == COUNT_BITS'(CLASS_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.head  = cell_data[0];

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CLASS_DEPTH)
      else $error("class occupancy beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("push into a full class");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty && !push)
      else $error("pop from an empty class or together with push");

endmodule

`default_nettype wire

@@ rtl/two_class_priority_queue.sv @@
// Top level of the two-class strict-priority queue.
`default_nettype none

// Two-class strict-priority queue. A command is taken at every clock edge with
// start high and busy low; busy stays low, so one command per cycle is
// sustained. Each command gives exactly one result, shown for one cycle with
// rsp_strobe high in the cycle after it was taken; the receiver cannot stall.
// Enqueue (req_mode 0) appends req_entry_id to the class named by
// req_is_priority, or sets rsp_enqueue_refused when that class is full. Serve
// (req_mode 1) returns the oldest priority entry, else the oldest normal entry,
// else rsp_served_valid low. Each class is a row of CLASS_DEPTH cells whose
// head sits in the first cell; a serve shifts every cell of the row towards
// the head. No clearing pass runs after reset.
module two_class_priority_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_mode,
   input  wire                               req_is_priority,
   input  wire  [15:0]                       req_entry_id,
   output logic                              rsp_strobe,
   output logic                              rsp_served_valid,
   output logic [15:0]                       rsp_served_id,
   output logic                              rsp_served_priority,
   output logic                              rsp_enqueue_refused,
   output logic [tcpq_pkg::TOTAL_BITS-1:0]   rsp_total_queued
);
   import tcpq_pkg::*;

   tcpq_class_stat_type   prio_stat;
   tcpq_class_stat_type   norm_stat;
   logic                  accept;
   logic                  is_serve;
   logic                  prio_push;
   logic                  norm_push;
   logic                  prio_pop;
   logic                  norm_pop;
   logic [STORE_BITS-1:0] store_id;
   logic [COUNT_BITS:0]   total_next;

   logic                  strobe_ff;
   logic                  strobe_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [PORT_BITS-1:0]  id_ff;
   logic [PORT_BITS-1:0]  id_in;
   logic                  sprio_ff;
   logic                  sprio_in;
   logic                  refused_ff;
   logic                  refused_in;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_serve = (req_mode == MODE_SERVE);
   assign store_id = req_entry_id[STORE_BITS-1:0];

   // Command decode into class push and pop
   assign prio_push = accept && !is_serve && req_is_priority && !prio_stat.full;
   assign norm_push = accept && !is_serve && !req_is_priority && !norm_stat.full;
   assign prio_pop  = accept && is_serve && !prio_stat.empty;
   assign norm_pop  = accept && is_serve && prio_stat.empty && !norm_stat.empty;

   tcpq_class u_prio (
      .clock     (clock),
      .reset     (reset),
      .push      (prio_push),
      .pop       (prio_pop),
      .push_data (store_id),
      .stat      (prio_stat)
   );

   tcpq_class u_norm (
      .clock     (clock),
      .reset     (reset),
      .push      (norm_push),
      .pop       (norm_pop),
      .push_data (store_id),
      .stat      (norm_stat)
   );

   // Occupancy after this command, saturated to the field
   always_comb begin
      total_next = (COUNT_BITS+1)'(prio_stat.count) + (COUNT_BITS+1)'(norm_stat.count);
      if (prio_push || norm_push) begin
         total_next = total_next + (COUNT_BITS+1)'(1);
      end else if (prio_pop || norm_pop) begin
         total_next = total_next - (COUNT_BITS+1)'(1);
      end
   end

   // Result register
   always_comb begin
      strobe_in  = accept;
      valid_in   = prio_pop || norm_pop;
      sprio_in   = prio_pop;
      refused_in = accept && !is_serve && !(prio_push || norm_push);
      id_in      = '0;
      if (prio_pop) begin
         id_in = PORT_BITS'(prio_stat.head);
      end else if (norm_pop) begin
         id_in = PORT_BITS'(norm_stat.head);
      end
      if (int'(total_next) > TOTAL_MAX) begin
         total_in = TOTAL_BITS'(TOTAL_MAX);
      end else begin
         total_in = TOTAL_BITS'(total_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff   <= valid_in;
      id_ff      <= id_in;
      sprio_ff   <= sprio_in;
      refused_ff <= refused_in;
      total_ff   <= total_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_served_valid    = valid_ff;
   assign rsp_served_id       = id_ff;
   assign rsp_served_priority = sprio_ff;
   assign rsp_enqueue_refused = refused_ff;
   assign rsp_total_queued    = total_ff;

   // Checks
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("taken command gave no result transfer");
   a_serve_xor_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_served_valid && rsp_enqueue_refused))
      else $error("result both served and refused");
   a_empty_serve_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_served_valid |-> rsp_served_id == '0 && !rsp_served_priority)
      else $error("served fields set without a served entry");
   a_strict_order: assert property (@(posedge clock) disable iff (reset)
      norm_pop |-> prio_stat.empty)
      else $error("normal entry served while priority entries wait");

endmodule

`default_nettype wire

@@ tb/tb_two_class_priority_queue.sv @@
// Self-checking testbench for the two-class strict-priority queue.
`default_nettype none

module tb_two_class_priority_queue;
   import tcpq_pkg::*;

   // One response as the block presents it.
   typedef struct packed {
      logic                  served_valid;
      logic [15:0]           served_id;
      logic                  served_priority;
      logic                  enqueue_refused;
      logic [TOTAL_BITS-1:0] total_queued;
   } served_result_type;

   // Tracks both class queues and the responses still owed by the block.
   class serve_order_scoreboard;
      logic [15:0]       priority_ids[$];
      logic [15:0]       normal_ids[$];
      served_result_type owed_results[$];
      int                mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Apply one accepted command and queue the response it must give.
      function void note_command(logic mode, logic is_prio, logic [15:0] id);
         served_result_type r;
         logic [15:0]       kept_id;
         int                held;
         r = '0;
         kept_id = id & ~(16'hFFFF << STORE_BITS);
         if (mode == MODE_ENQUEUE) begin
            if (is_prio) begin
               if (priority_ids.size() >= CLASS_DEPTH) r.enqueue_refused = 1'b1;
               else priority_ids.push_back(kept_id);
            end else begin
               if (normal_ids.size() >= CLASS_DEPTH) r.enqueue_refused = 1'b1;
               else normal_ids.push_back(kept_id);
            end
         end else begin
            // strict priority: priority class first, then normal
            if (priority_ids.size() > 0) begin
               r.served_valid    = 1'b1;
               r.served_priority = 1'b1;
               r.served_id       = priority_ids.pop_front();
            end else if (normal_ids.size() > 0) begin
               r.served_valid = 1'b1;
               r.served_id    = normal_ids.pop_front();
            end
         end
         held = priority_ids.size() + normal_ids.size();
         r.total_queued = (held > TOTAL_MAX) ? TOTAL_BITS'(TOTAL_MAX) : TOTAL_BITS'(held);
         owed_results.push_back(r);
      endfunction

      // Compare one response with the oldest owed one.
      function void check_result(served_result_type got);
         served_result_type want;
         if (owed_results.size() == 0) begin
            $error("response with nothing owed: id %h valid %b", got.served_id,
                   got.served_valid);
            mismatch_count++;
            return;
         end
         want = owed_results.pop_front();
         if (got.served_valid !== want.served_valid) begin
            $error("served_valid: expected %b, actual %b", want.served_valid,
                   got.served_valid);
            mismatch_count++;
         end
         if (got.served_id !== want.served_id) begin
            $error("served_id: expected %h, actual %h", want.served_id, got.served_id);
            mismatch_count++;
         end
         if (got.served_priority !== want.served_priority) begin
            $error("served_priority: expected %b, actual %b", want.served_priority,
                   got.served_priority);
            mismatch_count++;
         end
         if (got.enqueue_refused !== want.enqueue_refused) begin
            $error("enqueue_refused: expected %b, actual %b", want.enqueue_refused,
                   got.enqueue_refused);
            mismatch_count++;
         end
         if (got.total_queued !== want.total_queued) begin
            $error("total_queued: expected %0d, actual %0d", want.total_queued,
                   got.total_queued);
            mismatch_count++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 500;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  req_mode = MODE_ENQUEUE;
   logic                  req_is_priority = 1'b0;
   logic [15:0]           req_entry_id = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_served_valid;
   logic [15:0]           rsp_served_id;
   logic                  rsp_served_priority;
   logic                  rsp_enqueue_refused;
   logic [TOTAL_BITS-1:0] rsp_total_queued;

   serve_order_scoreboard queue_sb = new();
   int                    stall_cycles = 0;

   two_class_priority_queue i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_is_priority     (req_is_priority),
      .req_entry_id        (req_entry_id),
      .rsp_strobe          (rsp_strobe),
      .rsp_served_valid    (rsp_served_valid),
      .rsp_served_id       (rsp_served_id),
      .rsp_served_priority (rsp_served_priority),
      .rsp_enqueue_refused (rsp_enqueue_refused),
      .rsp_total_queued    (rsp_total_queued)
   );

   // 8-unit clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor: note command transfers, check responses, count quiet cycles.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         queue_sb.note_command(req_mode, req_is_priority, req_entry_id);
      if (!reset && rsp_strobe)
         queue_sb.check_result({rsp_served_valid, rsp_served_id, rsp_served_priority,
                                rsp_enqueue_refused, rsp_total_queued});
      if ((start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   // Watchdog on cycles with no transfer at all.
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("two_class_priority_queue regression: fail");
      $finish;
   end

   // Present one command and hold it until the block takes it.
   task automatic send_command(input logic mode, input logic is_prio,
                               input logic [15:0] id);
      start           <= 1'b1;
      req_mode        <= mode;
      req_is_priority <= is_prio;
      req_entry_id    <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random traffic in bursts, each with its own enqueue and class bias,
   // so both classes run full and run dry many times.
   task automatic random_traffic(input int items);
      int          enq_pct;
      int          prio_pct;
      int          burst_left;
      logic        mode;
      logic        is_prio;
      logic [15:0] id;
      burst_left = 0;
      enq_pct    = 50;
      prio_pct   = 50;
      for (int n = 0; n < items; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 10);
            case ($urandom_range(3))
               0: enq_pct = 20;
               1: enq_pct = 50;
               2: enq_pct = 80;
               default: enq_pct = 97;
            endcase
            case ($urandom_range(3))
               0: prio_pct = 0;
               1: prio_pct = 30;
               2: prio_pct = 70;
               default: prio_pct = 100;
            endcase
         end
         burst_left--;
         mode    = ($urandom_range(99) < enq_pct) ? MODE_ENQUEUE : MODE_SERVE;
         is_prio = ($urandom_range(99) < prio_pct);
         case ($urandom_range(15))
            0: id = 16'h0000;
            1: id = 16'hFFFF;
            default: id = 16'($urandom);
         endcase
         // a long quiet-free stretch in the middle
         if ((n < 500 || n >= 800) && $urandom_range(99) < 5)
            hold_idle($urandom_range(4, 1));
         send_command(mode, is_prio, id);
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // serve on empty, both classes, class ordering
      send_command(MODE_SERVE, 1'b1, 16'hFFFF);
      send_command(MODE_ENQUEUE, 1'b0, 16'h0000);
      send_command(MODE_ENQUEUE, 1'b1, 16'hFFFF);
      send_command(MODE_SERVE, 1'b0, 16'h1234);
      send_command(MODE_SERVE, 1'b1, 16'h0000);
      send_command(MODE_SERVE, 1'b0, 16'h0000);
      // fill the priority class, then one refused transfer
      for (int k = 0; k < CLASS_DEPTH + 1; k++)
         send_command(MODE_ENQUEUE, 1'b1, 16'(16'hA5A5 ^ (k * 16'h1111)));
      send_command(MODE_SERVE, 1'b0, 16'h5A5A);
      send_command(MODE_SERVE, 1'b1, 16'hFFFF);

      random_traffic(1200);

      start <= 1'b0;
      while (queue_sb.owed_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (queue_sb.mismatch_count == 0 && queue_sb.owed_results.size() == 0)
         $display("two_class_priority_queue regression: pass");
      else
         $display("two_class_priority_queue regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
